[rtl/core/rwps_pkg.sv]
// Shared types and constants of the roulette wheel parent selector.
package rwps_pkg;

  localparam int SUM_W     = 28;
  localparam int FIT_W     = 20;
  localparam int WORD_W    = 31;
  localparam int POP_W     = 9;
  localparam int PAIRS_W   = 16;
  localparam int OUT_IDX_W = 8;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [SUM_W-1:0]   SUM_MAX         = {SUM_W{1'b1}};
  localparam logic [POP_W-1:0]   POP_SIZE_RESET  = POP_W'(256);
  localparam logic [PAIRS_W-1:0] PAIRS_RESET     = PAIRS_W'(1);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_e;

  typedef enum logic {
    REG_POP_SIZE = 1'b0,
    REG_PAIRS    = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_PICK
  } rwps_state_e;

  typedef struct packed {
    op_e                operation;
    logic               restart_load;
    logic [FIT_W-1:0]   fitness_hundredths;
    logic [WORD_W-1:0]  random_word;
  } rwps_in_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] parent_first;
    logic [OUT_IDX_W-1:0] parent_second;
    logic                 fell_back_uniform;
    logic                 last_pair;
  } rwps_out_t;

endpackage

[rtl/core/rwps_chan_if.sv]
// Valid/ready channel carrying one word of a given payload type.
interface rwps_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/rwps_mod_unit.sv]
// Bit-serial restoring modulo: dividend mod divisor, one dividend bit per cycle.
module rwps_mod_unit
  import rwps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [WORD_W-1:0] dividend_i,
  input  logic [SUM_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [SUM_W-1:0]  rem_o
);

  localparam int STEP_W = $clog2(WORD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(WORD_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] cnt_q;
  logic [WORD_W-1:0] word_q;
  logic [SUM_W-1:0]  div_q;
  logic [SUM_W-1:0]  rem_q;

  logic [SUM_W:0]    trial;
  logic [SUM_W:0]    diff;
  logic [SUM_W-1:0]  rem_nx;

  assign trial  = {rem_q, word_q[WORD_W-1]};
  assign diff   = trial - {1'b0, div_q};
  // remainder stays below the divisor, so the low bits hold it after a subtract
  assign rem_nx = (trial >= {1'b0, div_q}) ? diff[SUM_W-1:0] : trial[SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST_STEP);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + STEP_W'(1);
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      word_q <= dividend_i;
      div_q  <= divisor_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      word_q <= {word_q[WORD_W-2:0], 1'b0};
      rem_q  <= rem_nx;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("modulo start while busy");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> divisor_i != '0)
    else $error("modulo started with zero divisor");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rem_q < div_q)
    else $error("modulo remainder not below divisor");

endmodule

[rtl/core/roulette_wheel_parent_selector_core.sv]
// Roulette wheel parent selector: prefix-sum store, serial modulo and binary search.
// Load word: taken in idle, ready again the next cycle.
// Draw word: serial modulo in the shared modulo unit, a read and a compare state per binary search step
//   (8 steps at 256 entries), a closing search read and a pick state; a uniform draw skips the search.
// One word is in work at a time, ready again the cycle after; a full result register stalls pick.
// Reset clears counts, total, pair state and configuration registers; prefix store is not cleared.
module roulette_wheel_parent_selector_core
  import rwps_pkg::*;
#(
  parameter int MAX_POPULATION = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  rwps_chan_if.sink         in_i,
  rwps_chan_if.source       out_o
);

  localparam int IDX_W = $clog2(MAX_POPULATION);
  localparam int CNT_W = $clog2(MAX_POPULATION + 1);
  localparam int CAP_W = (CNT_W > POP_W) ? CNT_W : POP_W;
  localparam logic [CAP_W-1:0] MAX_POP_C = CAP_W'(MAX_POPULATION);

  // ---------------- configuration registers ----------------
  logic [POP_W-1:0]   pop_size_q;
  logic [PAIRS_W-1:0] pairs_wanted_q;
  logic               cfg_wr;
  reg_idx_e           cfg_sel;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_size_q     <= POP_SIZE_RESET;
      pairs_wanted_q <= PAIRS_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_POP_SIZE: pop_size_q     <= pwdata[POP_W-1:0];
        REG_PAIRS:    pairs_wanted_q <= pwdata[PAIRS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_POP_SIZE: prdata = APB_DW'(pop_size_q);
      REG_PAIRS:    prdata = APB_DW'(pairs_wanted_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------- state ----------------
  rwps_state_e        state_q, state_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [SUM_W-1:0]   total_q;
  logic               pending_q;
  logic [IDX_W-1:0]   held_q;
  logic [PAIRS_W-1:0] pairs_done_q;
  logic               uni_q;
  logic [SUM_W-1:0]   r_q;
  logic [IDX_W-1:0]   lo_q;
  logic [IDX_W-1:0]   hi_q;
  logic [IDX_W-1:0]   mid_q;
  logic               out_valid_q;
  rwps_out_t          out_q;

  logic [SUM_W-1:0]   mem [MAX_POPULATION];
  logic [SUM_W-1:0]   rd_q;

  // ---------------- control ----------------
  logic in_ready;
  logic accept;
  logic load_fire;
  logic draw_fire;
  logic mod_done;
  logic [SUM_W-1:0] mod_rem;
  logic search_go;
  logic emit;
  logic is_retry;

  assign accept    = in_i.valid && in_ready;
  assign load_fire = accept && (in_i.data.operation == OP_LOAD);
  assign draw_fire = accept && (in_i.data.operation == OP_DRAW);
  assign search_go = lo_q < hi_q;
  assign is_retry  = pending_q && (lo_q == held_q);

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    emit     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (draw_fire) begin
          state_d = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_d = uni_q ? ST_PICK : ST_SRCH_RD;
        end
      end
      ST_SRCH_RD: begin
        state_d = search_go ? ST_SRCH_CMP : ST_PICK;
      end
      ST_SRCH_CMP: begin
        state_d = ST_SRCH_RD;
      end
      ST_PICK: begin
        if (!pending_q || is_retry) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_o.ready) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_i.ready = in_ready;

  // ---------------- load path ----------------
  logic [CNT_W-1:0] cnt_eff;
  logic [SUM_W-1:0] total_eff;
  logic [CAP_W-1:0] cap_c;
  logic             room;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;

  assign cnt_eff   = in_i.data.restart_load ? '0 : cnt_q;
  assign total_eff = in_i.data.restart_load ? '0 : total_q;
  assign cap_c     = (CAP_W'(pop_size_q) > MAX_POP_C) ? MAX_POP_C : CAP_W'(pop_size_q);
  assign room      = CAP_W'(cnt_eff) < cap_c;
  assign sum_wide  = {1'b0, total_eff} + (SUM_W + 1)'(in_i.data.fitness_hundredths);
  assign sum_sat   = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

  // ---------------- shared modulo unit ----------------
  logic [CAP_W-1:0] uni_n;
  logic [SUM_W-1:0] divisor;

  assign uni_n   = (cap_c == '0) ? CAP_W'(1) : cap_c;
  assign divisor = (total_q == '0) ? SUM_W'(uni_n) : total_q;

  rwps_mod_unit u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (draw_fire),
    .dividend_i (in_i.data.random_word),
    .divisor_i  (divisor),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  // ---------------- search ----------------
  logic [IDX_W-1:0] mid;
  logic [IDX_W:0]   mid_sum;
  logic [CNT_W-1:0] cnt_m1;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IDX_W:1];
  assign cnt_m1  = cnt_q - CNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (load_fire && room) begin
      mem[cnt_eff[IDX_W-1:0]] <= sum_sat;
    end
    if (state_q == ST_SRCH_RD) begin
      rd_q <= mem[mid];
    end
  end

  always_ff @(posedge clk_i) begin
    if (draw_fire) begin
      uni_q <= (total_q == '0);
    end
    if (state_q == ST_MOD && mod_done) begin
      r_q <= mod_rem;
      if (uni_q) begin
        lo_q <= mod_rem[IDX_W-1:0];
      end else begin
        lo_q <= '0;
        hi_q <= cnt_m1[IDX_W-1:0];
      end
    end
    if (state_q == ST_SRCH_RD) begin
      mid_q <= mid;
    end
    if (state_q == ST_SRCH_CMP) begin
      // first entry whose prefix sum exceeds the remainder
      if (r_q < rd_q) begin
        hi_q <= mid_q;
      end else begin
        lo_q <= mid_q + IDX_W'(1);
      end
    end
  end

  // ---------------- pair bookkeeping and result ----------------
  logic last;

  assign last = ({1'b0, pairs_done_q} + (PAIRS_W + 1)'(1)) >= {1'b0, pairs_wanted_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      total_q      <= '0;
      pending_q    <= 1'b0;
      held_q       <= '0;
      pairs_done_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_o.ready && !emit) begin
        out_valid_q <= 1'b0;
      end
      if (load_fire) begin
        if (in_i.data.restart_load) begin
          pending_q    <= 1'b0;
          pairs_done_q <= '0;
        end
        cnt_q   <= room ? cnt_eff + CNT_W'(1) : cnt_eff;
        total_q <= room ? sum_sat : total_eff;
      end
      if (state_q == ST_PICK && !pending_q) begin
        held_q    <= lo_q;
        pending_q <= 1'b1;
      end
      if (emit) begin
        out_valid_q  <= 1'b1;
        pending_q    <= 1'b0;
        pairs_done_q <= last ? '0 : pairs_done_q + PAIRS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.parent_first      <= OUT_IDX_W'(held_q);
      out_q.parent_second     <= OUT_IDX_W'(lo_q);
      out_q.fell_back_uniform <= uni_q;
      out_q.last_pair         <= last;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  a_total_has_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q != '0 |-> cnt_q != '0)
    else $error("nonzero total with empty store");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_POPULATION))
    else $error("loaded count beyond store depth");

  a_search_in_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH_RD && search_go) |-> CNT_W'(hi_q) < cnt_q)
    else $error("search reads an unloaded entry");

endmodule
